[design/rgb_led_pwm_breathing_controller_assert.svh]
`ifndef RGB_LED_PWM_BREATHING_CONTROLLER_ASSERT_SVH
`define RGB_LED_PWM_BREATHING_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RGBPWM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RGBPWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/rgbpwm_pkg.sv]
package rgbpwm_pkg;

  localparam int CHANNELS_DEF  = 3;
  localparam int PWM_STEPS_DEF = 100;

  localparam int LEVEL_W    = 7;
  localparam int CHAR_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int DELAY_W    = 34;

  localparam logic [CFG_DATA_W-1:0] RESET_TICK_US  = 10'd100;
  localparam logic [CFG_DATA_W-1:0] RESET_REFRESH  = 10'd300;
  localparam logic [DELAY_W-1:0]    RESET_DELAY_US = 34'd100000;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH_PERIOD = 2'd1;

  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_R    = 8'h52;
  localparam logic [CHAR_W-1:0] CHAR_G    = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_B    = 8'h42;
  localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_E    = 8'h45;
  localparam logic [CHAR_W-1:0] CHAR_N    = 8'h4E;
  localparam logic [CHAR_W-1:0] CHAR_F    = 8'h46;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ONE  = 8'h31;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

  typedef struct packed {
    logic              op;
    logic [CHAR_W-1:0] target_char;
    logic [CHAR_W-1:0] mode_char;
    logic [CHAR_W-1:0] arg_a;
    logic [CHAR_W-1:0] arg_b;
  } item_t;

  typedef struct packed {
    logic led_red;
    logic led_green;
    logic led_blue;
  } led_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [DELAY_W-1:0] pow10(input logic [3:0] e);
    logic [DELAY_W-1:0] p;
    case (e)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

[design/rgb_led_pwm_breathing_controller.sv]
// RGB LED PWM controller with breathing. Each word on cmd is either a four-character
// command (channel R, G, B or A; then EN/EF, E<digit><exponent> for the effect delay,
// or a three-digit level capped at PWM_STEPS) or a timer tick. Every tick yields one
// word on pwm with the three LED bits; commands yield none. The block takes one word
// per clock while cmd_stall is low: it is held in the input register and applied to
// the state at an edge with no output stall, where its LED word enters the output
// register; a tick thus passes both registers before it shows on pwm. cmd_stall
// rises only while the input register holds a word and a finished LED word is
// stalled. cfg_ready is always high; write the registers only while the block is idle.
module rgb_led_pwm_breathing_controller #(
  parameter int CHANNELS  = rgbpwm_pkg::CHANNELS_DEF,
  parameter int PWM_STEPS = rgbpwm_pkg::PWM_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  rgbpwm_pkg::item_t                   cmd,
  output logic                                pwm_valid,
  input  logic                                pwm_stall,
  output rgbpwm_pkg::led_t                    pwm,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rgbpwm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgbpwm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rgbpwm_pkg::*;

  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W     = $clog2(2 * CHANNELS) + 1;
  localparam int LED_LIMIT = (CHANNELS < 3) ? CHANNELS : 3;
  localparam logic [LEVEL_W-1:0] STEPS = LEVEL_W'(PWM_STEPS);
  localparam logic [SUM_W-1:0]   CH_N  = SUM_W'(CHANNELS);

  item_t                 in_q;
  logic                  in_q_valid;
  logic [CFG_DATA_W-1:0] tick_period_us;
  logic [CFG_DATA_W-1:0] refresh_period;
  logic [LEVEL_W-1:0]    commanded_level [CHANNELS];
  logic [LEVEL_W-1:0]    applied_level   [CHANNELS];
  logic [CHANNELS-1:0]   breathing_enabled;
  logic [LEVEL_W-1:0]    pwm_counter;
  logic [CFG_DATA_W-1:0] refresh_counter;
  logic [DELAY_W-1:0]    effect_delay_us;
  logic [DELAY_W-1:0]    elapsed_us;
  logic [LEVEL_W-1:0]    ramp_level;
  logic                  ramp_falling;
  logic [CH_W-1:0]       ramp_channel;

  logic hold, take, work, is_tick;

  logic [CHANNELS-1:0] target_mask;
  logic                target_ok;
  logic                a_dig, b_dig;
  logic                set_enable, set_delay, set_level;
  logic [CHAR_W-1:0]   level_raw;
  logic [LEVEL_W-1:0]  level_cap;
  logic [DELAY_W-1:0]  delay_next;

  logic [LEVEL_W-1:0]    applied_now [CHANNELS];
  led_t                  leds;
  logic [CFG_DATA_W:0]   refresh_inc;
  logic [CFG_DATA_W-1:0] refresh_counter_next;
  logic [LEVEL_W:0]      pwm_inc;
  logic [LEVEL_W-1:0]    pwm_counter_next;
  logic                  any_enabled;
  logic [DELAY_W-1:0]    elapsed_sum;
  logic                  step_due;

  logic [LEVEL_W-1:0] adv_level;
  logic               adv_falling;
  logic [SUM_W-1:0]   scan_pos;
  logic [SUM_W-1:0]   scan_wrap;
  logic [SUM_W-1:0]   hit_pos;
  logic [SUM_W-1:0]   hit_wrap_pos;
  logic [CH_W-1:0]    hit_ch;
  logic [SUM_W-1:0]   next_pos;
  logic               next_wraps;
  logic [CH_W-1:0]    ramp_channel_next;
  logic [LEVEL_W-1:0] write_level;

  assign hold      = pwm_valid & pwm_stall;
  assign cmd_stall = in_q_valid & hold;
  assign take      = cmd_valid & ~cmd_stall;
  assign work      = in_q_valid & ~hold;
  assign is_tick   = (in_q.op == OP_TICK);
  assign cfg_ready = 1'b1;

  // command decode
  always_comb begin
    target_mask = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      case (in_q.target_char)
        CHAR_R:  target_mask[c] = (c == 0);
        CHAR_G:  target_mask[c] = (c == 1);
        CHAR_B:  target_mask[c] = (c == 2);
        CHAR_A:  target_mask[c] = 1'b1;
        default: target_mask[c] = 1'b0;
      endcase
    end
    target_ok  = |target_mask;
    a_dig      = is_digit(in_q.arg_a);
    b_dig      = is_digit(in_q.arg_b);
    set_enable = (in_q.mode_char == CHAR_E) &&
                 ((in_q.arg_a == CHAR_N) || (in_q.arg_a == CHAR_F));
    set_delay  = (in_q.mode_char == CHAR_E) && !set_enable && a_dig && b_dig;
    set_level  = ((in_q.mode_char == CHAR_ZERO) || (in_q.mode_char == CHAR_ONE)) &&
                 a_dig && b_dig;
    level_raw  = ((in_q.mode_char == CHAR_ONE) ? 8'd100 : 8'd0) +
                 CHAR_W'({4'd0, in_q.arg_a[3:0]} * 8'd10) +
                 CHAR_W'(in_q.arg_b[3:0]);
    level_cap  = (level_raw > CHAR_W'(PWM_STEPS)) ? STEPS : level_raw[LEVEL_W-1:0];
    delay_next = DELAY_W'(in_q.arg_a[3:0] * pow10(in_q.arg_b[3:0]));
  end

  // tick: latch, compare, count
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      applied_now[c] = (refresh_counter == '0) ? commanded_level[c] : applied_level[c];
    end
    leds = '0;
    for (int c = 0; c < LED_LIMIT; c++) begin
      case (c)
        0:       leds.led_red   = (pwm_counter < applied_now[c]);
        1:       leds.led_green = (pwm_counter < applied_now[c]);
        default: leds.led_blue  = (pwm_counter < applied_now[c]);
      endcase
    end
    refresh_inc          = {1'b0, refresh_counter} + 1'b1;
    refresh_counter_next = (refresh_inc >= {1'b0, refresh_period}) ?
                           '0 : refresh_inc[CFG_DATA_W-1:0];
    pwm_inc              = {1'b0, pwm_counter} + 1'b1;
    pwm_counter_next     = (pwm_inc >= (LEVEL_W + 1)'(PWM_STEPS)) ?
                           '0 : pwm_inc[LEVEL_W-1:0];
    any_enabled          = |breathing_enabled;
    elapsed_sum          = elapsed_us + DELAY_W'(tick_period_us);
    step_due             = (elapsed_sum >= effect_delay_us);
  end

  // breathing ramp: next enabled channel at or after the current position
  always_comb begin
    if (!ramp_falling) begin
      adv_falling = (ramp_level >= STEPS);
      adv_level   = (ramp_level >= STEPS) ? STEPS : ramp_level + 1'b1;
    end else begin
      adv_falling = (ramp_level != '0);
      adv_level   = (ramp_level == '0) ? ramp_level : ramp_level - 1'b1;
    end
    hit_pos = SUM_W'(ramp_channel);
    for (int k = CHANNELS - 1; k >= 0; k--) begin
      scan_pos  = SUM_W'(ramp_channel) + SUM_W'(k);
      scan_wrap = (scan_pos >= CH_N) ? scan_pos - CH_N : scan_pos;
      if (breathing_enabled[scan_wrap[CH_W-1:0]]) begin
        hit_pos = scan_pos;
      end
    end
    hit_wrap_pos      = (hit_pos >= CH_N) ? hit_pos - CH_N : hit_pos;
    hit_ch            = hit_wrap_pos[CH_W-1:0];
    write_level       = (hit_pos >= CH_N) ? adv_level : ramp_level;
    next_pos          = hit_pos + 1'b1;
    next_wraps        = (next_pos >= CH_N);
    ramp_channel_next = next_wraps ? CH_W'(next_pos - CH_N) : CH_W'(next_pos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid        <= 1'b0;
      pwm_valid         <= 1'b0;
      tick_period_us    <= RESET_TICK_US;
      refresh_period    <= RESET_REFRESH;
      breathing_enabled <= '0;
      pwm_counter       <= '0;
      refresh_counter   <= '0;
      effect_delay_us   <= RESET_DELAY_US;
      elapsed_us        <= '0;
      ramp_level        <= '0;
      ramp_falling      <= 1'b0;
      ramp_channel      <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        commanded_level[c] <= '0;
        applied_level[c]   <= '0;
      end
    end else begin
      if (take) begin
        in_q_valid <= 1'b1;
      end else if (work) begin
        in_q_valid <= 1'b0;
      end

      if (work && is_tick) begin
        pwm_valid <= 1'b1;
      end else if (!pwm_stall) begin
        pwm_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_TICK_PERIOD:    tick_period_us <= cfg_data;
          REG_REFRESH_PERIOD: refresh_period <= cfg_data;
          default: ;
        endcase
      end

      if (work && !is_tick && target_ok) begin
        if (set_delay) begin
          effect_delay_us <= delay_next;
        end
        for (int c = 0; c < CHANNELS; c++) begin
          if (target_mask[c] && set_enable) begin
            breathing_enabled[c] <= (in_q.arg_a == CHAR_N);
          end
          if (target_mask[c] && set_level) begin
            commanded_level[c] <= level_cap;
          end
        end
      end

      if (work && is_tick) begin
        for (int c = 0; c < CHANNELS; c++) begin
          applied_level[c] <= applied_now[c];
        end
        refresh_counter <= refresh_counter_next;
        pwm_counter     <= pwm_counter_next;
        if (!any_enabled) begin
          elapsed_us <= '0;
        end else if (!step_due) begin
          elapsed_us <= elapsed_sum;
        end else begin
          elapsed_us              <= '0;
          commanded_level[hit_ch] <= write_level;
          ramp_channel            <= ramp_channel_next;
          if (next_wraps) begin
            ramp_level   <= adv_level;
            ramp_falling <= adv_falling;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_q <= cmd;
    end
    if (work && is_tick) begin
      pwm <= leds;
    end
  end

endmodule

[design/rgbpwm_checker.sv]
`include "rgb_led_pwm_breathing_controller_assert.svh"

module rgbpwm_assertions (
  input logic             clk,
  input logic             rst,
  input logic             cmd_stall,
  input logic             pwm_valid,
  input logic             pwm_stall,
  input rgbpwm_pkg::led_t pwm,
  input logic             cfg_ready
);
  import rgbpwm_pkg::*;

  `RGBPWM_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready, "config port not ready")
  `RGBPWM_ASSERT_NOW(a_stall_when_full, cmd_stall, pwm_valid && pwm_stall, "stall with room")
  `RGBPWM_ASSERT_NOW(a_empty_after_reset, $past(rst), !pwm_valid, "word right after reset")
  `RGBPWM_ASSERT_NEXT(a_hold, pwm_valid && pwm_stall, pwm_valid && $stable(pwm), "word changed")

endmodule

bind rgb_led_pwm_breathing_controller rgbpwm_assertions u_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_stall (cmd_stall),
  .pwm_valid (pwm_valid),
  .pwm_stall (pwm_stall),
  .pwm       (pwm),
  .cfg_ready (cfg_ready)
);

[tb/rgbpwm_checker.sv]
`timescale 1ns / 1ps

module rgbpwm_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  input  logic                              cmd_stall,
  input  rgbpwm_pkg::item_t                 cmd,
  input  logic                              pwm_valid,
  input  logic                              pwm_stall,
  input  rgbpwm_pkg::led_t                  pwm,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [rgbpwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbpwm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                errors,
  output int                                outstanding
);
  import rgbpwm_pkg::*;

  localparam int NCH   = CHANNELS_DEF;
  localparam int STEPS = PWM_STEPS_DEF;

  logic [CFG_DATA_W-1:0] tick_us;
  logic [CFG_DATA_W-1:0] refresh_len;
  logic [LEVEL_W-1:0]    want_level [NCH];
  logic                  breathe_on [NCH];
  logic [LEVEL_W-1:0]    lit_level [NCH];
  logic [LEVEL_W-1:0]    duty_count;
  logic [CFG_DATA_W-1:0] refresh_count;
  logic [DELAY_W-1:0]    step_delay;
  logic [DELAY_W-1:0]    since_step;
  logic [LEVEL_W-1:0]    ramp_lvl;
  logic                  ramp_down;
  logic [1:0]            ramp_ch;

  led_t leds_due [$];
  int   fails;

  function automatic logic is_dec(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic any_breathing();
    logic hit;
    hit = 1'b0;
    for (int c = 0; c < NCH; c++) hit |= breathe_on[c];
    return hit;
  endfunction

  task automatic clear_model();
    tick_us       = RESET_TICK_US;
    refresh_len   = RESET_REFRESH;
    duty_count    = '0;
    refresh_count = '0;
    step_delay    = RESET_DELAY_US;
    since_step    = '0;
    ramp_lvl      = '0;
    ramp_down     = 1'b0;
    ramp_ch       = '0;
    for (int c = 0; c < NCH; c++) begin
      want_level[c] = '0;
      breathe_on[c] = 1'b0;
      lit_level[c]  = '0;
    end
  endtask

  task automatic ramp_advance();
    if (int'(ramp_ch) + 1 < NCH) begin
      ramp_ch = ramp_ch + 1'b1;
    end else begin
      ramp_ch = '0;
      if (!ramp_down) begin
        if (int'(ramp_lvl) >= STEPS) begin
          ramp_lvl  = LEVEL_W'(STEPS);
          ramp_down = 1'b1;
        end else begin
          ramp_lvl = ramp_lvl + 1'b1;
        end
      end else if (ramp_lvl == '0) begin
        ramp_down = 1'b0;
      end else begin
        ramp_lvl = ramp_lvl - 1'b1;
      end
    end
  endtask

  task automatic ramp_write();
    logic [1:0]         ch;
    logic [LEVEL_W-1:0] lvl;
    logic               en;
    logic               done;
    done = 1'b0;
    for (int n = 0; n <= NCH && !done; n++) begin
      ch  = ramp_ch;
      lvl = ramp_lvl;
      en  = breathe_on[ch];
      ramp_advance();
      if (en) begin
        want_level[ch] = lvl;
        done = 1'b1;
      end
    end
  endtask

  task automatic decode_command(input item_t w);
    int                 lo;
    int                 hi;
    int                 lvl;
    int                 ex;
    logic               known;
    logic [DELAY_W-1:0] d;
    known = 1'b1;
    lo = 0;
    hi = 0;
    if (w.target_char == CHAR_R) begin
      lo = 0; hi = 0;
    end else if (w.target_char == CHAR_G) begin
      lo = 1; hi = 1;
    end else if (w.target_char == CHAR_B) begin
      lo = 2; hi = 2;
    end else if (w.target_char == CHAR_A) begin
      lo = 0; hi = NCH - 1;
    end else begin
      known = 1'b0;
    end
    if (known && lo < NCH) begin
      if (w.mode_char == CHAR_E) begin
        if (w.arg_a == CHAR_N || w.arg_a == CHAR_F) begin
          for (int c = lo; c <= hi; c++) breathe_on[c] = (w.arg_a == CHAR_N);
        end else if (is_dec(w.arg_a) && is_dec(w.arg_b)) begin
          d  = DELAY_W'(int'(w.arg_a) - int'(CHAR_ZERO));
          ex = int'(w.arg_b) - int'(CHAR_ZERO);
          for (int k = 0; k < ex; k++) d = d * 10;
          step_delay = d;
        end
      end else if (w.mode_char == CHAR_ZERO || w.mode_char == CHAR_ONE) begin
        if (is_dec(w.arg_a) && is_dec(w.arg_b)) begin
          lvl = 100 * (int'(w.mode_char) - int'(CHAR_ZERO))
              + 10 * (int'(w.arg_a) - int'(CHAR_ZERO))
              + (int'(w.arg_b) - int'(CHAR_ZERO));
          if (lvl > STEPS) lvl = STEPS;
          for (int c = lo; c <= hi; c++) want_level[c] = LEVEL_W'(lvl);
        end
      end
    end
  endtask

  task automatic predict_leds(output led_t o);
    if (refresh_count == '0) lit_level = want_level;
    o.led_red   = (NCH > 0) && (duty_count < lit_level[0]);
    o.led_green = (NCH > 1) && (duty_count < lit_level[1]);
    o.led_blue  = (NCH > 2) && (duty_count < lit_level[2]);
    refresh_count = (int'(refresh_count) + 1 >= int'(refresh_len)) ? '0
                                                                    : refresh_count + 1'b1;
    duty_count = (int'(duty_count) + 1 >= STEPS) ? '0 : duty_count + 1'b1;
    if (any_breathing()) begin
      since_step = since_step + tick_us;
      if (since_step >= step_delay) begin
        since_step = '0;
        ramp_write();
      end
    end else begin
      since_step = '0;
    end
  endtask

  always @(posedge clk) begin : watch
    led_t due;
    if (rst) begin
      clear_model();
      leds_due.delete();
      fails = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TICK_PERIOD) tick_us = cfg_data;
        else if (cfg_index == REG_REFRESH_PERIOD) refresh_len = cfg_data;
      end
      if (pwm_valid && !pwm_stall) begin
        if (leds_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("pwm word with nothing expected: r%0b g%0b b%0b",
                     pwm.led_red, pwm.led_green, pwm.led_blue);
        end else begin
          due = leds_due.pop_front();
          if (pwm.led_red !== due.led_red || pwm.led_green !== due.led_green ||
              pwm.led_blue !== due.led_blue) begin
            fails++;
            if (fails <= 10)
              $display("pwm mismatch: expected r%0b g%0b b%0b, got r%0b g%0b b%0b",
                       due.led_red, due.led_green, due.led_blue,
                       pwm.led_red, pwm.led_green, pwm.led_blue);
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        if (cmd.op == OP_TICK) begin
          predict_leds(due);
          leds_due.push_back(due);
        end else begin
          decode_command(cmd);
        end
      end
    end
    errors      <= fails;
    outstanding <= leds_due.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import rgbpwm_pkg::*;

  localparam int WATCH_LIMIT = 3000;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 285;
  localparam int SETTLE      = 6;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam logic [CHAR_W-1:0] BAD_TARGET = 8'h58;
  localparam logic [CHAR_W-1:0] BAD_MODE   = 8'h51;
  localparam logic [CHAR_W-1:0] NOT_DIGIT  = 8'h78;

  localparam logic [CHAR_W-1:0]     TARGETS     [4]      = '{CHAR_R, CHAR_G, CHAR_B, CHAR_A};
  localparam logic [CFG_DATA_W-1:0] TICK_SET    [PHASES] =
    '{10'd1, 10'd1000, 10'd100, 10'd0, 10'd1023, 10'd7};
  localparam logic [CFG_DATA_W-1:0] REFRESH_SET [PHASES] =
    '{10'd0, 10'd1, 10'd1023, 10'd5, 10'd300, 10'd37};

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cmd_valid = 1'b0;
  item_t                 cmd       = '0;
  logic                  pwm_stall = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  cmd_stall;
  logic                  pwm_valid;
  led_t                  pwm;
  logic                  cfg_ready;
  int                    errors;
  int                    outstanding;
  int                    quiet     = 0;
  int                    stall_hold = 0;

  always #6 clk = ~clk;

  rgb_led_pwm_breathing_controller u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .pwm_valid (pwm_valid),
    .pwm_stall (pwm_stall),
    .pwm       (pwm),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rgbpwm_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .pwm_valid   (pwm_valid),
    .pwm_stall   (pwm_stall),
    .pwm         (pwm),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      pwm_stall  <= 1'b1;
      stall_hold <= $urandom_range(0, 8);
    end else begin
      pwm_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 30);
    end
  end

  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (pwm_valid && !pwm_stall) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCH_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [CHAR_W-1:0] dig(input int n);
    return CHAR_ZERO + CHAR_W'(n);
  endfunction

  function automatic item_t command_word(input logic [CHAR_W-1:0] t, m, a, b);
    item_t w;
    w.op          = OP_COMMAND;
    w.target_char = t;
    w.mode_char   = m;
    w.arg_a       = a;
    w.arg_b       = b;
    return w;
  endfunction

  function automatic item_t tick_word();
    item_t w;
    w    = '0;
    w.op = OP_TICK;
    return w;
  endfunction

  function automatic item_t random_word();
    item_t w;
    int    pick;
    w.op          = OP_COMMAND;
    w.target_char = CHAR_W'($urandom);
    w.mode_char   = CHAR_W'($urandom);
    w.arg_a       = CHAR_W'($urandom);
    w.arg_b       = CHAR_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      w.op = OP_TICK;
    end else if (pick < 88) begin
      w.target_char = TARGETS[$urandom_range(0, 3)];
      case ($urandom_range(0, 2))
        0: begin
          w.mode_char = CHAR_E;
          w.arg_a     = ($urandom_range(0, 3) != 0) ? CHAR_N : CHAR_F;
        end
        1: begin
          w.mode_char = CHAR_E;
          w.arg_a     = dig($urandom_range(0, 9));
          w.arg_b     = dig(($urandom_range(0, 5) == 0) ? $urandom_range(0, 9)
                                                        : $urandom_range(0, 1));
        end
        default: begin
          w.mode_char = $urandom_range(0, 1) ? CHAR_ONE : CHAR_ZERO;
          w.arg_a     = dig($urandom_range(0, 9));
          w.arg_b     = dig($urandom_range(0, 9));
        end
      endcase
    end else if (pick < 94) begin
      w.target_char = TARGETS[$urandom_range(0, 3)];
      w.mode_char   = $urandom_range(0, 1) ? CHAR_E : CHAR_ONE;
      if ($urandom_range(0, 1)) w.arg_a = dig($urandom_range(0, 9));
      else w.arg_b = dig($urandom_range(0, 9));
    end
    return w;
  endfunction

  // hold the word until it is accepted
  task automatic send_word(input item_t w);
    cmd_valid <= 1'b1;
    cmd       <= w;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic idle_for(input int n);
    cmd_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic settle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] tick_len, refresh_len,
                              input logic spare);
    write_reg(REG_TICK_PERIOD, tick_len);
    write_reg(REG_REFRESH_PERIOD, refresh_len);
    if (spare)
      write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int   burst_left;
    item_t ones;
    burst_left = 0;
    ones       = '1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(tick_word());
    send_word(command_word(CHAR_A, CHAR_ONE, dig(9), dig(9)));
    send_word(tick_word());
    settle();
    program_regs(10'd1000, 10'd1, 1'b1);

    send_word(command_word(CHAR_A, CHAR_ONE, dig(9), dig(9)));
    send_word(tick_word());
    send_word(command_word(CHAR_R, CHAR_ZERO, dig(0), dig(0)));
    send_word(command_word(CHAR_G, CHAR_ZERO, dig(5), dig(0)));
    send_word(command_word(CHAR_B, CHAR_ONE, NOT_DIGIT, dig(5)));
    send_word(command_word(BAD_TARGET, CHAR_ZERO, dig(5), dig(0)));
    send_word(command_word(CHAR_A, BAD_MODE, dig(1), dig(2)));
    send_word(command_word(CHAR_A, CHAR_E, dig(7), NOT_DIGIT));
    send_word(tick_word());
    send_word(command_word(CHAR_A, CHAR_E, dig(0), dig(0)));
    send_word(command_word(CHAR_R, CHAR_E, CHAR_N, CHAR_N));
    send_word(tick_word());
    send_word(tick_word());
    send_word(command_word(CHAR_A, CHAR_E, CHAR_N, CHAR_ZERO));
    send_word(tick_word());
    send_word(tick_word());
    send_word(command_word(CHAR_G, CHAR_E, CHAR_F, CHAR_F));
    send_word(command_word(CHAR_A, CHAR_E, dig(9), dig(5)));
    send_word(tick_word());
    send_word(command_word(CHAR_A, CHAR_E, CHAR_F, CHAR_ZERO));
    send_word(tick_word());
    send_word(ones);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      program_regs(TICK_SET[p], REFRESH_SET[p], p[0]);
      burst_left = 0;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (p != 2 && burst_left == 0) begin
          idle_for($urandom_range(1, 12));
          burst_left = $urandom_range(1, 40);
        end
        send_word(random_word());
        if (burst_left > 0) burst_left--;
      end
    end

    settle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
